// ===== hw/rtl/ntre_pkg.sv =====
// ----------------------------------------------------------------------------
// ntre_pkg: shared constants and types for the NDEF text record extractor
// Store geometry, NDEF codes, status codes and the controller/datapath
// command and status structs.
// ----------------------------------------------------------------------------
package ntre_pkg;

    localparam int STORE_BYTES = 64;
    localparam int MAX_RESULTS = 64;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int CNT_W       = $clog2(STORE_BYTES + 1);
    // furthest read: tag slot, length, header, type length, four length
    // bytes, type, status byte and a language code of up to 63 bytes
    localparam int POS_W       = $clog2(STORE_BYTES + 68);
    localparam int N_W         = $clog2(MAX_RESULTS + 1);
    // text index plus two plus language length
    localparam int SUM_W       = $clog2(MAX_RESULTS + 2 + 64);

    localparam logic [7:0] TLV_NDEF  = 8'h03;
    localparam logic [7:0] SHORT_REC = 8'h10;
    localparam logic [7:0] TEXT_TYPE = 8'h54;
    localparam logic [7:0] LANG_MASK = 8'h3F;

    localparam logic [1:0] ST_TEXT     = 2'd0;
    localparam logic [1:0] ST_NO_MSG   = 2'd1;
    localparam logic [1:0] ST_NOT_TEXT = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_STORE,
        OP_SCAN_NEXT,
        OP_TLV_HIT,
        OP_HDR,
        OP_TLEN,
        OP_PAY_SHORT,
        OP_PAY_LONG,
        OP_TYPE,
        OP_LANG,
        OP_EMIT_NEXT
    } dp_op_t;

    typedef enum logic [1:0] {
        OUT_TEXT,
        OUT_EMPTY,
        OUT_NO_MSG,
        OUT_NOT_TEXT
    } out_kind_t;

    typedef struct packed {
        dp_op_t    op;
        logic      pos_clr;
        logic      cnt_clr;
        logic      out_ld;
        out_kind_t out_kind;
    } ntre_cmd_t;

    typedef struct packed {
        logic scan_live;
        logic is_ndef;
        logic short_rec;
        logic text_ok;
        logic emit_ok;
        logic emit_more;
    } ntre_sts_t;

endpackage

// ===== hw/rtl/ntre_dp.sv =====
// ----------------------------------------------------------------------------
// ntre_dp: datapath of the NDEF text record extractor
// Byte store, read pointer, parsed header fields and the result register.
// ----------------------------------------------------------------------------
module ntre_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ntre_pkg::ntre_cmd_t   cmd,
    input  logic [7:0]            s_data_byte,
    output ntre_pkg::ntre_sts_t   sts,
    output logic [7:0]            m_text_byte,
    output logic                  m_has_byte,
    output logic [1:0]            m_status,
    output logic                  m_end_of_run
);

    logic [7:0]                    mem [ntre_pkg::STORE_BYTES];
    logic [7:0]                    rd_data_reg;
    logic                          in_range_reg;
    logic [ntre_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [ntre_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [ntre_pkg::POS_W-1:0]    pos_inc;
    logic [ntre_pkg::POS_W-1:0]    count_ext;
    logic [7:0]                    hdr_reg;
    logic                          tlen_one_reg;
    logic [31:0]                   payload_reg;
    logic [5:0]                    lang_reg;
    logic [ntre_pkg::N_W-1:0]      n_reg;
    logic [ntre_pkg::N_W-1:0]      n_inc;
    logic [ntre_pkg::SUM_W-1:0]    need1, need2;
    logic [7:0]                    byte_val;
    logic                          store_room;
    logic [7:0]                    out_byte_reg;
    logic                          out_has_reg;
    logic [1:0]                    out_status_reg;
    logic                          out_eor_reg;

    assign byte_val   = in_range_reg ? rd_data_reg : 8'h00;
    assign store_room = count_reg < ntre_pkg::CNT_W'(ntre_pkg::STORE_BYTES);
    assign count_ext  = ntre_pkg::POS_W'(count_reg);
    assign pos_inc    = pos_reg + 1'b1;
    assign n_inc      = n_reg + 1'b1;
    assign need1      = ntre_pkg::SUM_W'(n_reg) + ntre_pkg::SUM_W'(lang_reg) + 1'b1;
    assign need2      = need1 + 1'b1;

    always_comb begin
        sts.scan_live = (pos_reg + ntre_pkg::POS_W'(5)) < count_ext;
        sts.is_ndef   = byte_val == ntre_pkg::TLV_NDEF;
        sts.short_rec = (hdr_reg & ntre_pkg::SHORT_REC) != 8'h00;
        sts.text_ok   = tlen_one_reg && (byte_val == ntre_pkg::TEXT_TYPE);
        sts.emit_ok   = (n_reg < ntre_pkg::N_W'(ntre_pkg::MAX_RESULTS))
                        && (pos_reg < count_ext)
                        && (payload_reg > 32'(need1));
        sts.emit_more = (n_inc < ntre_pkg::N_W'(ntre_pkg::MAX_RESULTS))
                        && (pos_inc < count_ext)
                        && (payload_reg > 32'(need2));
    end

    always_comb begin
        pos_next = pos_reg;
        if (cmd.pos_clr) begin
            pos_next = '0;
        end else begin
            case (cmd.op)
                ntre_pkg::OP_SCAN_NEXT,
                ntre_pkg::OP_HDR,
                ntre_pkg::OP_TLEN,
                ntre_pkg::OP_PAY_SHORT,
                ntre_pkg::OP_PAY_LONG,
                ntre_pkg::OP_TYPE,
                ntre_pkg::OP_EMIT_NEXT: begin
                    pos_next = pos_inc;
                end
                ntre_pkg::OP_TLV_HIT: begin
                    pos_next = pos_reg + ntre_pkg::POS_W'(2);
                end
                ntre_pkg::OP_LANG: begin
                    // step over the status byte and the language code
                    pos_next = pos_inc + ntre_pkg::POS_W'(byte_val & ntre_pkg::LANG_MASK);
                end
                default: begin
                    pos_next = pos_reg;
                end
            endcase
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.cnt_clr) begin
            count_next = '0;
        end else if (cmd.op == ntre_pkg::OP_STORE && store_room) begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            in_range_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            in_range_reg <= pos_reg < count_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == ntre_pkg::OP_STORE && store_room) begin
            mem[count_reg[ntre_pkg::ADDR_W-1:0]] <= s_data_byte;
        end
        rd_data_reg <= mem[pos_reg[ntre_pkg::ADDR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        case (cmd.op)
            ntre_pkg::OP_HDR: begin
                hdr_reg <= byte_val;
            end
            ntre_pkg::OP_TLEN: begin
                tlen_one_reg <= byte_val == 8'h01;
            end
            ntre_pkg::OP_PAY_SHORT: begin
                payload_reg <= {24'h000000, byte_val};
            end
            ntre_pkg::OP_PAY_LONG: begin
                payload_reg <= {payload_reg[23:0], byte_val};
            end
            ntre_pkg::OP_LANG: begin
                lang_reg <= byte_val[5:0];
                n_reg    <= '0;
            end
            ntre_pkg::OP_EMIT_NEXT: begin
                n_reg <= n_inc;
            end
            default: begin
            end
        endcase
        if (cmd.out_ld) begin
            out_has_reg  <= cmd.out_kind == ntre_pkg::OUT_TEXT;
            out_byte_reg <= (cmd.out_kind == ntre_pkg::OUT_TEXT) ? byte_val : 8'h00;
            out_eor_reg  <= (cmd.out_kind != ntre_pkg::OUT_TEXT) || !sts.emit_more;
            case (cmd.out_kind)
                ntre_pkg::OUT_NO_MSG:   out_status_reg <= ntre_pkg::ST_NO_MSG;
                ntre_pkg::OUT_NOT_TEXT: out_status_reg <= ntre_pkg::ST_NOT_TEXT;
                default:                out_status_reg <= ntre_pkg::ST_TEXT;
            endcase
        end
    end

    assign m_text_byte  = out_byte_reg;
    assign m_has_byte   = out_has_reg;
    assign m_status     = out_status_reg;
    assign m_end_of_run = out_eor_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= ntre_pkg::CNT_W'(ntre_pkg::STORE_BYTES))
        else $error("byte count beyond store size");

    a_tag_in_image: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == ntre_pkg::OP_TLV_HIT |-> in_range_reg && sts.is_ndef)
        else $error("tag hit outside the loaded image");

    a_text_in_image: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_ld && cmd.out_kind == ntre_pkg::OUT_TEXT |-> in_range_reg && sts.emit_ok)
        else $error("text word taken from outside the loaded image");

endmodule

// ===== hw/rtl/ntre_ctrl.sv =====
// ----------------------------------------------------------------------------
// ntre_ctrl: sequencer of the NDEF text record extractor
// Walks load, tag scan, record header, type check and text emission, and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module ntre_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_last,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  ntre_pkg::ntre_sts_t   sts,
    output ntre_pkg::ntre_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_SCAN_A,
        S_SCAN_B,
        S_HDR_A,
        S_HDR_B,
        S_TLEN_A,
        S_TLEN_B,
        S_PAY_A,
        S_PAY_B,
        S_TYPE_A,
        S_TYPE_B,
        S_LANG_A,
        S_LANG_B,
        S_EMIT_A,
        S_EMIT_B
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] k_reg, k_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = state_reg == S_LOAD;
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        cmd.op       = ntre_pkg::OP_NONE;
        cmd.pos_clr  = 1'b0;
        cmd.cnt_clr  = 1'b0;
        cmd.out_ld   = 1'b0;
        cmd.out_kind = ntre_pkg::OUT_TEXT;
        case (state_reg)
            S_LOAD: begin
                if (s_valid) begin
                    cmd.op = ntre_pkg::OP_STORE;
                    if (s_last) begin
                        cmd.pos_clr = 1'b1;
                        state_next  = S_SCAN_A;
                    end
                end
            end
            S_SCAN_A: begin
                if (sts.scan_live) begin
                    state_next = S_SCAN_B;
                end else if (out_free) begin
                    cmd.out_ld   = 1'b1;
                    cmd.out_kind = ntre_pkg::OUT_NO_MSG;
                    cmd.cnt_clr  = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            S_SCAN_B: begin
                if (sts.is_ndef) begin
                    cmd.op     = ntre_pkg::OP_TLV_HIT;
                    state_next = S_HDR_A;
                end else begin
                    cmd.op     = ntre_pkg::OP_SCAN_NEXT;
                    state_next = S_SCAN_A;
                end
            end
            S_HDR_A:  state_next = S_HDR_B;
            S_HDR_B: begin
                cmd.op     = ntre_pkg::OP_HDR;
                state_next = S_TLEN_A;
            end
            S_TLEN_A: state_next = S_TLEN_B;
            S_TLEN_B: begin
                cmd.op     = ntre_pkg::OP_TLEN;
                k_next     = 2'd0;
                state_next = S_PAY_A;
            end
            S_PAY_A:  state_next = S_PAY_B;
            S_PAY_B: begin
                if (sts.short_rec) begin
                    cmd.op     = ntre_pkg::OP_PAY_SHORT;
                    state_next = S_TYPE_A;
                end else begin
                    // long length: four words, most significant first
                    cmd.op     = ntre_pkg::OP_PAY_LONG;
                    k_next     = k_reg + 1'b1;
                    state_next = (k_reg == 2'd3) ? S_TYPE_A : S_PAY_A;
                end
            end
            S_TYPE_A: state_next = S_TYPE_B;
            S_TYPE_B: begin
                if (sts.text_ok) begin
                    cmd.op     = ntre_pkg::OP_TYPE;
                    state_next = S_LANG_A;
                end else if (out_free) begin
                    cmd.out_ld   = 1'b1;
                    cmd.out_kind = ntre_pkg::OUT_NOT_TEXT;
                    cmd.cnt_clr  = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            S_LANG_A: state_next = S_LANG_B;
            S_LANG_B: begin
                cmd.op     = ntre_pkg::OP_LANG;
                state_next = S_EMIT_A;
            end
            S_EMIT_A: state_next = S_EMIT_B;
            S_EMIT_B: begin
                // hold until the result register is free
                if (out_free) begin
                    cmd.out_ld = 1'b1;
                    if (sts.emit_ok) begin
                        cmd.out_kind = ntre_pkg::OUT_TEXT;
                        if (sts.emit_more) begin
                            cmd.op     = ntre_pkg::OP_EMIT_NEXT;
                            state_next = S_EMIT_A;
                        end else begin
                            cmd.cnt_clr = 1'b1;
                            state_next  = S_LOAD;
                        end
                    end else begin
                        cmd.out_kind = ntre_pkg::OUT_EMPTY;
                        cmd.cnt_clr  = 1'b1;
                        state_next   = S_LOAD;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_ld) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            k_reg       <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_ld |-> !m_valid_reg || m_ready)
        else $error("result register loaded while a word is pending");

    a_final_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_clr |=> state_reg == S_LOAD && m_valid_reg)
        else $error("run ended without a pending final word");

    a_status_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_ld && cmd.out_kind != ntre_pkg::OUT_TEXT |-> cmd.cnt_clr)
        else $error("status word did not close the run");

endmodule

// ===== hw/rtl/ndef_text_record_extract.sv =====
// ----------------------------------------------------------------------------
// ndef_text_record_extract: NDEF text record extractor
// Loads a tag memory image and returns the text of its first NDEF record.
// ----------------------------------------------------------------------------
// Input channel s_*: one word of tag memory per accepted word, s_last on the
// final word. Words are stored at one per cycle (up to 64, later words are
// dropped); s_ready is high only while loading.
// After the word with s_last the sequencer scans for the first NDEF tag and
// parses the record. Every byte read from the store, whether a byte searched
// in the scan, a byte of the record header, length, type or status fields,
// or a text byte, takes an address state followed by a state that uses the
// registered memory data; text bytes follow one another while the receiver
// keeps up.
// Result channel m_*: one word per text byte, or a single status word (no
// message, not a text record, or empty text); m_end_of_run marks the final
// word of the run. A single output register holds the word: when the receiver
// stalls, the sequencer holds until the register is free, and after the final
// word is loaded the block accepts the next image while that word still waits.
// Reset (aresetn low, synchronous) empties the store and returns to loading.
// ----------------------------------------------------------------------------
module ndef_text_record_extract (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_text_byte,
    output logic       m_has_byte,
    output logic [1:0] m_status,
    output logic       m_end_of_run
);

    ntre_pkg::ntre_cmd_t cmd;
    ntre_pkg::ntre_sts_t sts;

    ntre_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_last),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ntre_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .s_data_byte  (s_data_byte),
        .sts          (sts),
        .m_text_byte  (m_text_byte),
        .m_has_byte   (m_has_byte),
        .m_status     (m_status),
        .m_end_of_run (m_end_of_run)
    );

endmodule

// ===== sim/tb_ndef_text_record_extract.sv =====
// ----------------------------------------------------------------------------
// tb_ndef_text_record_extract: testbench for the NDEF text record extractor
// Loads tag memory images word by word: a short table of hand-built images
// first, then random images that are mostly well-formed text records (short
// and long form) with random content, mixed with wrong types, noise, tiny
// images, overfull images and absurd payload lengths. Table results are
// checked against the typed words, the others against a behavioural parser
// kept in step with the loaded bytes. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_ndef_text_record_extract;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIR_ROWS     = 24;
    localparam int RANDOM_ITEMS = 390;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 4000000;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       has_byte;
        logic [1:0] status;
        logic       end_of_run;
    } text_word_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
        logic       typed;
        text_word_t word;
    } load_row_t;

    typedef enum int {
        IMG_SHORT_TEXT,
        IMG_LONG_TEXT,
        IMG_WRONG_TYPE,
        IMG_NOISE,
        IMG_TINY,
        IMG_OVERFULL,
        IMG_EMPTY_TEXT,
        IMG_HUGE_LEN
    } img_kind_t;

    localparam text_word_t NO_WORD = '0;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_data_byte;
    logic       s_last;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_text_byte;
    logic       m_has_byte;
    logic [1:0] m_status;
    logic       m_end_of_run;

    // parser image of the block's store
    logic [7:0] tag_mem [ntre_pkg::STORE_BYTES];
    int         mem_fill = 0;

    text_word_t predicted_words [$];
    text_word_t text_expect_q [$];
    logic [7:0] img [$];
    int         err_count   = 0;
    int         cycle_count = 0;

    // hand-built images; the expected word is typed on each closing byte
    load_row_t dir_rows [DIR_ROWS] = '{
        // one zero byte: too short to hold a message
        {8'h00, 1'b1, 1'b1, {8'h00, 1'b0, ntre_pkg::ST_NO_MSG, 1'b1}},
        {8'hFF, 1'b1, 1'b1, {8'h00, 1'b0, ntre_pkg::ST_NO_MSG, 1'b1}},
        // short text record, language "en", text "A"
        {8'h03, 1'b0, 1'b0, NO_WORD},
        {8'h07, 1'b0, 1'b0, NO_WORD},
        {8'hD1, 1'b0, 1'b0, NO_WORD},
        {8'h01, 1'b0, 1'b0, NO_WORD},
        {8'h04, 1'b0, 1'b0, NO_WORD},
        {8'h54, 1'b0, 1'b0, NO_WORD},
        {8'h02, 1'b0, 1'b0, NO_WORD},
        {8'h65, 1'b0, 1'b0, NO_WORD},
        {8'h6E, 1'b0, 1'b0, NO_WORD},
        {8'h41, 1'b1, 1'b1, {8'h41, 1'b1, ntre_pkg::ST_TEXT, 1'b1}},
        // type length of two: not a text record
        {8'h03, 1'b0, 1'b0, NO_WORD},
        {8'h00, 1'b0, 1'b0, NO_WORD},
        {8'hD1, 1'b0, 1'b0, NO_WORD},
        {8'h02, 1'b0, 1'b0, NO_WORD},
        {8'h00, 1'b0, 1'b0, NO_WORD},
        {8'h55, 1'b1, 1'b1, {8'h00, 1'b0, ntre_pkg::ST_NOT_TEXT, 1'b1}},
        // tag too close to the end to be searched
        {8'h00, 1'b0, 1'b0, NO_WORD},
        {8'h03, 1'b0, 1'b0, NO_WORD},
        {8'h00, 1'b0, 1'b0, NO_WORD},
        {8'h00, 1'b0, 1'b0, NO_WORD},
        {8'h00, 1'b0, 1'b0, NO_WORD},
        {8'h00, 1'b1, 1'b1, {8'h00, 1'b0, ntre_pkg::ST_NO_MSG, 1'b1}}
    };

    ndef_text_record_extract uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_text_byte  (m_text_byte),
        .m_has_byte   (m_has_byte),
        .m_status     (m_status),
        .m_end_of_run (m_end_of_run)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        b = rand_byte();
        if (b == ntre_pkg::TLV_NDEF) b = 8'h04;
        return b;
    endfunction

    // mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic logic [7:0] mem_at(longint unsigned p);
        if (p < mem_fill) return tag_mem[p];
        return 8'h00;
    endfunction

    // parse the loaded image into the words it should produce
    function automatic void predict_text();
        longint unsigned p;
        logic [7:0]      hdr;
        logic [7:0]      tlen;
        logic [31:0]     pay;
        longint          pay_n;
        longint          text_n;
        int              lang_n;
        int              n;
        bit              hit;
        text_word_t      w;
        predicted_words.delete();
        hit = 1'b0;
        p   = 0;
        for (int i = 0; i + 5 < mem_fill; i++) begin
            if (!hit && tag_mem[i] == ntre_pkg::TLV_NDEF) begin
                hit = 1'b1;
                p   = i + 2;
            end
        end
        if (!hit) begin
            w = '{8'h00, 1'b0, ntre_pkg::ST_NO_MSG, 1'b1};
            predicted_words.push_back(w);
            return;
        end
        hdr  = mem_at(p);
        tlen = mem_at(p + 1);
        p += 2;
        if ((hdr & ntre_pkg::SHORT_REC) != 8'h00) begin
            pay = {24'h0, mem_at(p)};
            p += 1;
        end else begin
            pay = '0;
            repeat (4) begin
                pay = {pay[23:0], mem_at(p)};
                p += 1;
            end
        end
        if (tlen != 8'd1 || mem_at(p) != ntre_pkg::TEXT_TYPE) begin
            w = '{8'h00, 1'b0, ntre_pkg::ST_NOT_TEXT, 1'b1};
            predicted_words.push_back(w);
            return;
        end
        p += 1;
        lang_n = mem_at(p) & ntre_pkg::LANG_MASK;
        p += 1 + lang_n;
        pay_n  = pay;
        text_n = pay_n - 1 - lang_n;
        n = 0;
        while (n < text_n && p < mem_fill && n < ntre_pkg::MAX_RESULTS) begin
            w = '{mem_at(p), 1'b1, ntre_pkg::ST_TEXT, 1'b0};
            predicted_words.push_back(w);
            p += 1;
            n++;
        end
        if (n == 0) begin
            w = '{8'h00, 1'b0, ntre_pkg::ST_TEXT, 1'b1};
            predicted_words.push_back(w);
        end else begin
            w = predicted_words[n - 1];
            w.end_of_run = 1'b1;
            predicted_words[n - 1] = w;
        end
    endfunction

    // hold the word on the channel until taken, then fold it into the store
    task automatic load_word(input logic [7:0] b, input logic lst, input logic typed,
                             input text_word_t typed_word, input bit quiet);
        int gap;
        gap = quiet ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last      <= lst;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (mem_fill < ntre_pkg::STORE_BYTES) begin
            tag_mem[mem_fill] = b;
            mem_fill++;
        end
        if (lst) begin
            predict_text();
            if (typed) text_expect_q.push_back(typed_word);
            else foreach (predicted_words[k]) text_expect_q.push_back(predicted_words[k]);
            mem_fill = 0;
        end
    endtask

    task automatic build_image(input img_kind_t kind);
        int          lang_n;
        int          text_n;
        int          cut;
        logic [7:0]  hdr;
        logic [7:0]  tlen;
        logic [7:0]  typ;
        logic [7:0]  st_b;
        logic [31:0] pay;
        bit          long_form;
        img.delete();
        if (kind == IMG_NOISE || kind == IMG_TINY) begin
            repeat (kind == IMG_TINY ? $urandom_range(1, 5) : $urandom_range(6, 24))
                img.push_back(rand_byte());
            if ($urandom_range(0, 2) == 0)
                img[$urandom_range(0, img.size() - 1)] = ntre_pkg::TLV_NDEF;
            return;
        end
        repeat ($urandom_range(0, 4)) img.push_back(junk_byte());
        img.push_back(ntre_pkg::TLV_NDEF);
        img.push_back(rand_byte());
        long_form = (kind == IMG_LONG_TEXT || kind == IMG_HUGE_LEN) ? 1'b1 :
                    (kind == IMG_SHORT_TEXT) ? 1'b0 : 1'($urandom_range(0, 1));
        hdr    = rand_byte();
        hdr[4] = ~long_form;
        tlen   = 8'd1;
        typ    = ntre_pkg::TEXT_TYPE;
        if (kind == IMG_WRONG_TYPE) begin
            if ($urandom_range(0, 1) == 1) begin
                tlen = rand_byte();
                if (tlen == 8'd1) tlen = 8'd2;
            end else begin
                typ = rand_byte();
                if (typ == ntre_pkg::TEXT_TYPE) typ = 8'h55;
            end
        end
        lang_n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 5);
        case (kind)
            IMG_EMPTY_TEXT: text_n = 0;
            IMG_OVERFULL:   text_n = $urandom_range(50, 70);
            default: begin
                text_n = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 50) :
                                                       $urandom_range(0, 12);
            end
        endcase
        pay = 1 + lang_n + text_n;
        if (kind == IMG_HUGE_LEN) begin
            case ($urandom_range(0, 3))
                0:       pay = '1;
                1:       pay = '0;
                2:       pay = 32'h8000_0000;
                default: pay = $urandom();
            endcase
        end else if (kind != IMG_EMPTY_TEXT && $urandom_range(0, 4) == 0) begin
            pay = pay + $urandom_range(0, 6) - 3;
        end
        img.push_back(hdr);
        img.push_back(tlen);
        if (long_form) begin
            img.push_back(pay[31:24]);
            img.push_back(pay[23:16]);
            img.push_back(pay[15:8]);
        end
        img.push_back(pay[7:0]);
        img.push_back(typ);
        st_b      = rand_byte();
        st_b[5:0] = lang_n[5:0];
        img.push_back(st_b);
        repeat (lang_n) img.push_back(rand_byte());
        repeat (text_n) img.push_back(rand_byte());
        repeat ($urandom_range(0, 3)) img.push_back(rand_byte());
        if (kind == IMG_OVERFULL) begin
            while (img.size() < 70) img.push_back(rand_byte());
        end else if ($urandom_range(0, 5) == 0) begin
            // drop the tail so the record runs off the end of the image
            cut = $urandom_range(1, img.size() / 2);
            repeat (cut) void'(img.pop_back());
        end
    endtask

    initial begin : stimulus
        img_kind_t kind;
        int        img_no;
        int        sent;
        int        r;
        bit        quiet;
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_data_byte <= 8'h00;
        s_last      <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        for (int k = 0; k < DIR_ROWS; k++) begin
            load_word(dir_rows[k].data_byte, dir_rows[k].is_last, dir_rows[k].typed,
                      dir_rows[k].word, 1'b0);
        end

        img_no = 0;
        sent   = 0;
        while (sent < RANDOM_ITEMS) begin
            case (img_no)
                0: kind = IMG_OVERFULL;
                1: kind = IMG_EMPTY_TEXT;
                2: kind = IMG_HUGE_LEN;
                3: kind = IMG_LONG_TEXT;
                default: begin
                    r = $urandom_range(0, 99);
                    if (r < 35)      kind = IMG_SHORT_TEXT;
                    else if (r < 55) kind = IMG_LONG_TEXT;
                    else if (r < 63) kind = IMG_WRONG_TYPE;
                    else if (r < 73) kind = IMG_NOISE;
                    else if (r < 79) kind = IMG_TINY;
                    else if (r < 85) kind = IMG_OVERFULL;
                    else if (r < 92) kind = IMG_EMPTY_TEXT;
                    else             kind = IMG_HUGE_LEN;
                end
            endcase
            build_image(kind);
            quiet = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < img.size(); k++) begin
                load_word(img[k], k == img.size() - 1, 1'b0, NO_WORD, quiet);
            end
            sent += img.size();
            img_no++;
        end
        s_valid <= 1'b0;
        s_last  <= 1'b0;

        while (text_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // receiver: runs of ready broken by stalls, some runs long
    initial begin : receiver
        int run;
        int stall;
        m_ready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            run = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 150) :
                                                $urandom_range(1, 6);
            m_ready <= 1'b1;
            repeat (run) @(posedge aclk);
            stall = idle_len();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : text_check
        text_word_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (text_expect_q.size() == 0) begin
                $error("unexpected word: text_byte %02h has_byte %0d status %0d end_of_run %0d",
                       m_text_byte, m_has_byte, m_status, m_end_of_run);
                err_count++;
            end else begin
                want = text_expect_q.pop_front();
                if (m_text_byte !== want.text_byte) begin
                    $error("text_byte: expected %02h, got %02h", want.text_byte, m_text_byte);
                    err_count++;
                end
                if (m_has_byte !== want.has_byte) begin
                    $error("has_byte: expected %0d, got %0d", want.has_byte, m_has_byte);
                    err_count++;
                end
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    err_count++;
                end
                if (m_end_of_run !== want.end_of_run) begin
                    $error("end_of_run: expected %0d, got %0d", want.end_of_run, m_end_of_run);
                    err_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
